// ----- design/block_chain_table_engine_assert.svh -----
// Assertion macros shared by the block chain table engine RTL
`ifndef BLOCK_CHAIN_TABLE_ENGINE_ASSERT_SVH
`define BLOCK_CHAIN_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every clk edge outside reset
`define BCTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcte assertion failed");

// Next-cycle implication, checked on every clk edge outside reset
`define BCTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcte assertion failed");

`endif

// ----- design/bcte_pkg.sv -----
// Types and constants of the block chain table engine
package bcte_pkg;

  localparam int BLK_W  = 13;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;
  localparam int ACT_W  = 2;

  // in_tdata: action, block, next_block, count, padded to whole bytes
  localparam int IN_W  = 40;
  // out_tdata: block_out, status, freed, padded to whole bytes
  localparam int OUT_W = 32;

  localparam logic [ACT_W-1:0] ACT_SCAN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NEXT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LINK = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FREE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_END        = 3'd1;
  localparam logic [STAT_W-1:0] ST_SHORT      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BROKEN     = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE      = 3'd4;

  typedef struct packed {
    logic [BLK_W-1:0]  block_out;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  freed;
    logic              last;
  } res_t;

endpackage

// ----- design/block_chain_table_engine.sv -----
// Block chain table engine: allocation table walker built around one table memory
// Scan tests one block per cycle, except while a free block waits for the output slot, and free
// visits one entry per cycle, both set by the single read port of the table memory.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass writes every
// table entry to free with in_tready low; cfg writes are always taken.
`include "block_chain_table_engine_assert.svh"

module block_chain_table_engine #(
  parameter int NUM_BLOCKS = 4096,
  parameter int MAX_SCAN   = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bcte_pkg::BLK_W-1:0]  cfg_data,    // blocks_in_use
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [1:0] action, [14:2] block, [27:15] next_block, [34:28] count, [39:35] zero
  input  logic [bcte_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [12:0] block_out, [15:13] status, [28:16] freed, [31:29] zero
  output logic [bcte_pkg::OUT_W-1:0]  out_tdata,
  output logic                        out_tlast
);
  import bcte_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [16:0]   NB_W     = 17'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);
  localparam logic [CNT_W-1:0] SCAN_MAX = CNT_W'(MAX_SCAN);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_SCAN_EV, S_READ_EV, S_FREE_EV, S_FAIL, S_EMIT
  } state_t;

  function automatic logic [AW-1:0] blk_addr(input logic [BLK_W-1:0] b);
    logic [BLK_W-1:0] m;
    m = b - BLK_W'(1);
    blk_addr = AW'(m);
  endfunction

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [BLK_W-1:0]  cfg_r;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [BLK_W-1:0]  nb_r, nb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BLK_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic [BLK_W-1:0]  steps_r, steps_nxt;
  logic [BLK_W-1:0]  freed_r, freed_nxt;
  res_t              res_r, res_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_r, out_nxt;

  logic [BLK_W-1:0]  table_mem [NUM_BLOCKS];
  logic [BLK_W-1:0]  rd_data_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BLK_W-1:0]  mem_wdata;

  logic [BLK_W-1:0]  n;
  logic              out_free;
  logic [ACT_W-1:0]  in_action;
  logic [BLK_W-1:0]  in_block, in_next;
  logic [CNT_W-1:0]  in_count;
  logic [BLK_W-1:0]  entry, steps_inc, freed_inc;
  logic [CNT_W-1:0]  found_inc;

  assign in_action = in_tdata[1:0];
  assign in_block  = in_tdata[14:2];
  assign in_next   = in_tdata[27:15];
  assign in_count  = in_tdata[34:28];

  // effective table size: blocks_in_use clamped to the table depth
  assign n = ({4'b0, cfg_r} > NB_W) ? NB_W[BLK_W-1:0] : cfg_r;

  assign out_free  = !out_vld_r || out_tready;
  assign entry     = rd_data_r;
  assign steps_inc = steps_r + BLK_W'(1);
  assign freed_inc = freed_r + BLK_W'(1);
  assign found_inc = found_r + CNT_W'(1);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b0, out_r.freed, out_r.status, out_r.block_out};
  assign out_tlast  = out_r.last;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    act_nxt     = act_r;
    blk_nxt     = blk_r;
    nb_nxt      = nb_r;
    cnt_nxt     = cnt_r;
    cur_nxt     = cur_r;
    found_nxt   = found_r;
    steps_nxt   = steps_r;
    freed_nxt   = freed_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_tready;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = '0;
    mem_wdata   = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_action;
          blk_nxt   = in_block;
          nb_nxt    = in_next;
          cnt_nxt   = (in_count > SCAN_MAX) ? SCAN_MAX : in_count;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (act_r == ACT_SCAN) begin
          if (cnt_r == '0) begin
            res_nxt   = '{block_out: '0, status: ST_OK, freed: '0, last: 1'b1};
            state_nxt = S_EMIT;
          end else if (n == '0) begin
            state_nxt = S_FAIL;
          end else begin
            cur_nxt   = BLK_W'(1);
            found_nxt = '0;
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = S_SCAN_EV;
          end
        end else if (blk_r == '0 || blk_r > n) begin
          res_nxt   = '{block_out: '0, status: ST_RANGE, freed: '0, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          case (act_r)
            ACT_NEXT: begin
              mem_re    = 1'b1;
              mem_raddr = blk_addr(blk_r);
              state_nxt = S_READ_EV;
            end
            ACT_LINK: begin
              if (nb_r > n) begin
                res_nxt = '{block_out: '0, status: ST_RANGE, freed: '0, last: 1'b1};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = blk_addr(blk_r);
                mem_wdata = nb_r;
                res_nxt   = '{block_out: nb_r, status: ST_OK, freed: '0, last: 1'b1};
              end
              state_nxt = S_EMIT;
            end
            default: begin
              cur_nxt   = blk_r;
              steps_nxt = '0;
              freed_nxt = '0;
              mem_re    = 1'b1;
              mem_raddr = blk_addr(blk_r);
              state_nxt = S_FREE_EV;
            end
          endcase
        end
      end
      S_SCAN_EV: begin
        // hold the read data while a free block waits for the output slot
        if (entry != '0 || out_free) begin
          if (entry == '0) begin
            out_vld_nxt = 1'b1;
            out_nxt     = '{block_out: cur_r, status: ST_OK, freed: '0,
                            last: (found_inc == cnt_r)};
            found_nxt   = found_inc;
          end
          if (entry == '0 && found_inc == cnt_r) begin
            state_nxt = S_IDLE;
          end else if (cur_r == n) begin
            state_nxt = S_FAIL;
          end else begin
            cur_nxt   = cur_r + BLK_W'(1);
            mem_re    = 1'b1;
            mem_raddr = AW'(cur_r);
          end
        end
      end
      S_READ_EV: begin
        if (entry == '0 || entry > n) begin
          res_nxt = '{block_out: '0, status: ST_BROKEN, freed: '0, last: 1'b1};
        end else if (entry == blk_r) begin
          res_nxt = '{block_out: blk_r, status: ST_END, freed: '0, last: 1'b1};
        end else begin
          res_nxt = '{block_out: entry, status: ST_OK, freed: '0, last: 1'b1};
        end
        state_nxt = S_EMIT;
      end
      S_FREE_EV: begin
        // clear the visited entry and fetch the next link in the same cycle
        mem_we    = 1'b1;
        mem_waddr = blk_addr(cur_r);
        if (entry == '0) begin
          res_nxt   = '{block_out: '0, status: ST_BROKEN, freed: freed_r, last: 1'b1};
          state_nxt = S_EMIT;
        end else if (entry == cur_r) begin
          res_nxt   = '{block_out: '0, status: ST_OK, freed: freed_inc, last: 1'b1};
          state_nxt = S_EMIT;
        end else if (entry > n || steps_inc >= n) begin
          res_nxt   = '{block_out: '0, status: ST_BROKEN, freed: freed_inc, last: 1'b1};
          state_nxt = S_EMIT;
        end else begin
          cur_nxt   = entry;
          steps_nxt = steps_inc;
          freed_nxt = freed_inc;
          mem_re    = 1'b1;
          mem_raddr = blk_addr(entry);
        end
      end
      S_FAIL: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_nxt     = '{block_out: '0, status: ST_SHORT, freed: '0, last: 1'b1};
          state_nxt   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          out_nxt     = res_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
    act_r   <= act_nxt;
    blk_r   <= blk_nxt;
    nb_r    <= nb_nxt;
    cnt_r   <= cnt_nxt;
    cur_r   <= cur_nxt;
    found_r <= found_nxt;
    steps_r <= steps_nxt;
    freed_r <= freed_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= BLK_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[mem_raddr];
    end
  end

  `BCTE_ASSERT_NOW(a_rw_distinct, mem_we && mem_re, mem_waddr != mem_raddr)
  `BCTE_ASSERT_NOW(a_scan_count, state_r == S_SCAN_EV, found_r < cnt_r)
  `BCTE_ASSERT_NOW(a_free_cur, state_r == S_FREE_EV, cur_r != '0)
  `BCTE_ASSERT_NEXT(a_accept_start, in_tvalid && in_tready, state_r == S_START)

endmodule

// ----- sim/block_chain_table_engine_tb.sv -----
// Self-checking testbench for the block chain table engine: directed rows, then random phases
module block_chain_table_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcte_pkg::*;

  localparam int NUM_BLOCKS  = 4096;
  localparam int MAX_SCAN    = 64;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BLK_W-1:0]  block;
    logic [BLK_W-1:0]  next_block;
    logic [CNT_W-1:0]  count;
    logic              typed;
    logic [BLK_W-1:0]  t_block;
    logic [STAT_W-1:0] t_status;
    logic [BLK_W-1:0]  t_freed;
  } request_t;

  typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BLK_W-1:0]  cfg_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tlast;

  // Shadow allocation table and register
  logic [BLK_W-1:0] link_table [NUM_BLOCKS];
  logic [BLK_W-1:0] blocks_in_use_reg;

  res_t     step_results[$];
  res_t     awaited_results[$];
  request_t directed_rows[$];

  int mismatches;
  int cycle_count;
  int burst_left;

  int unsigned phase_size [6] = '{16, 1, 0, 8191, 40, 7};
  int          phase_items[6] = '{18, 6, 6, 16, 20, 14};

  block_chain_table_engine #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .MAX_SCAN  (MAX_SCAN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int table_len();
    return (blocks_in_use_reg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_in_use_reg);
  endfunction

  function automatic void queue_result(input logic [BLK_W-1:0] blk, input logic [STAT_W-1:0] st,
                                       input logic [BLK_W-1:0] fr, input logic lst);
    res_t res;
    res.block_out = blk;
    res.status    = st;
    res.freed     = fr;
    res.last      = lst;
    step_results.insert(step_results.size(), res);
  endfunction

  // Apply one transaction to the shadow table and leave its results in step_results
  function automatic void apply_table_action(input request_t r);
    int n;
    int b;
    int want;
    int found;
    int cur;
    int steps;
    int freed_cnt;
    logic walk_done;
    logic [BLK_W-1:0] e;
    logic [STAT_W-1:0] st;
    step_results.delete();
    n = table_len();
    if (r.action == ACT_SCAN) begin
      if (r.count == 0) begin
        queue_result(0, ST_OK, 0, 1'b1);
        return;
      end
      want = (r.count > MAX_SCAN) ? MAX_SCAN : int'(r.count);
      found = 0;
      for (b = 1; b <= n && found < want; b++) begin
        if (link_table[b-1] == 0) begin
          queue_result(BLK_W'(b), ST_OK, 0, found + 1 == want);
          found++;
        end
      end
      if (found < want) queue_result(0, ST_SHORT, 0, 1'b1);
      return;
    end
    if (r.block == 0 || r.block > n) begin
      queue_result(0, ST_RANGE, 0, 1'b1);
      return;
    end
    case (r.action)
      ACT_NEXT: begin
        e = link_table[r.block-1];
        if (e == 0 || e > n) queue_result(0, ST_BROKEN, 0, 1'b1);
        else if (e == r.block) queue_result(r.block, ST_END, 0, 1'b1);
        else queue_result(e, ST_OK, 0, 1'b1);
      end
      ACT_LINK: begin
        if (r.next_block > n) begin
          queue_result(0, ST_RANGE, 0, 1'b1);
        end else begin
          link_table[r.block-1] = r.next_block;
          queue_result(r.next_block, ST_OK, 0, 1'b1);
        end
      end
      default: begin
        // Clear each visited entry; stop at an end mark, a free entry, a bad link or n steps
        cur = r.block;
        steps = 0;
        freed_cnt = 0;
        st = ST_BROKEN;
        walk_done = 1'b0;
        while (!walk_done) begin
          if (steps >= n) begin
            walk_done = 1'b1;
          end else begin
            steps++;
            e = link_table[cur-1];
            link_table[cur-1] = 0;
            if (e == 0) begin
              walk_done = 1'b1;
            end else begin
              freed_cnt++;
              if (e == cur) begin
                st = ST_OK;
                walk_done = 1'b1;
              end else if (e > n) begin
                walk_done = 1'b1;
              end else begin
                cur = e;
              end
            end
          end
        end
        queue_result(0, st, BLK_W'(freed_cnt), 1'b1);
      end
    endcase
  endfunction

  function automatic request_t make_req(input logic [ACT_W-1:0] act, input int blk,
                                        input int nxt, input int cnt);
    request_t r;
    r = '0;
    r.action     = act;
    r.block      = BLK_W'(blk);
    r.next_block = BLK_W'(nxt);
    r.count      = CNT_W'(cnt);
    return r;
  endfunction

  function automatic request_t typed_req(input logic [ACT_W-1:0] act, input int blk,
                                         input int nxt, input int cnt, input int tb,
                                         input logic [STAT_W-1:0] ts, input int tf);
    request_t r;
    r = make_req(act, blk, nxt, cnt);
    r.typed    = 1'b1;
    r.t_block  = BLK_W'(tb);
    r.t_status = ts;
    r.t_freed  = BLK_W'(tf);
    return r;
  endfunction

  function automatic request_t noise_item(input int n);
    request_t r;
    int top;
    top = (n + 2 > 127) ? 127 : n + 2;
    r = make_req(ACT_W'($urandom_range(0, 3)), 0, 0, 0);
    r.block = BLK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(0, n + 1));
    case ($urandom_range(0, 3))
      0:       r.next_block = BLK_W'($urandom_range(0, 8191));
      1:       r.next_block = r.block;
      default: r.next_block = BLK_W'($urandom_range(0, n + 1));
    endcase
    r.count = CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(1, top));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_request(input request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - ACT_W - 2*BLK_W - CNT_W){1'b0}},
                  r.count, r.next_block, r.block, r.action};
    do @(posedge clk); while (!in_tready);
    apply_table_action(r);
    if (r.typed) begin
      awaited_results.insert(awaited_results.size(),
                             res_t'({r.t_block, r.t_status, r.t_freed, 1'b1}));
    end else begin
      foreach (step_results[i]) awaited_results.insert(awaited_results.size(), step_results[i]);
    end
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_blocks_in_use(input logic [BLK_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    blocks_in_use_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build a chain of distinct blocks, read back some of its links, scan, then maybe free from one of its blocks
  task automatic send_chain_walk(input int n, output int issued);
    int picks[8];
    int cap;
    int len;
    int k;
    int j;
    int tail;
    int top;
    logic fresh;
    issued = 0;
    cap = (n < 8) ? n : 8;
    top = (n + 2 > 127) ? 127 : n + 2;
    len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(1, cap);
    for (k = 0; k < len; k++) begin
      do begin
        picks[k] = $urandom_range(1, n);
        fresh = 1'b1;
        for (j = 0; j < k; j++) if (picks[j] == picks[k]) fresh = 1'b0;
      end while (!fresh);
    end
    case ($urandom_range(0, 9))
      7, 8:    tail = picks[0];
      9:       tail = 0;
      default: tail = picks[len-1];
    endcase
    for (k = 0; k < len; k++) begin
      send_request(make_req(ACT_LINK, picks[k], (k == len - 1) ? tail : picks[k+1],
                            $urandom_range(0, 127)));
      issued++;
    end
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 2) != 0) begin
        send_request(make_req(ACT_NEXT, picks[k], $urandom_range(0, 8191),
                              $urandom_range(0, 127)));
        issued++;
      end
    end
    send_request(make_req(ACT_SCAN, $urandom_range(0, 8191), $urandom_range(0, 8191),
                          $urandom_range(1, top)));
    issued++;
    if ($urandom_range(0, 3) != 0) begin
      send_request(make_req(ACT_FREE, picks[$urandom_range(0, len - 1)],
                            $urandom_range(0, 8191), $urandom_range(0, 127)));
      issued++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing awaited: block_out %0d status %0d freed %0d last %0b",
                 $time, out_tdata[12:0], out_tdata[15:13], out_tdata[28:16], out_tlast);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[12:0] !== want.block_out) begin
          $display("%0t: block_out expected %0d got %0d", $time, want.block_out, out_tdata[12:0]);
          mismatches++;
        end
        if (out_tdata[15:13] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_tdata[15:13]);
          mismatches++;
        end
        if (out_tdata[28:16] !== want.freed) begin
          $display("%0t: freed expected %0d got %0d", $time, want.freed, out_tdata[28:16]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall patterns
  initial begin
    rx_mode_t mode;
    int run;
    int tick;
    out_tready = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      run  = $urandom_range(4, 40);
      repeat (run) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_OPEN:  out_tready <= 1'b1;
          RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
          RX_THIRD: out_tready <= (tick % 3 == 0);
          default:  out_tready <= (tick % 5 == 0);
        endcase
      end
    end
  end

  initial begin
    int sent;
    int got;
    int n;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 0;
    blocks_in_use_reg = 13'd4096;
    foreach (link_table[i]) link_table[i] = '0;

    // Table size 4096 after reset, table all free
    directed_rows.insert(directed_rows.size(), typed_req(ACT_SCAN, 0, 0, 0, 0, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_SCAN, 8191, 8191, 3));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_NEXT, 0, 0, 1, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_NEXT, 4097, 0, 1, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(),
                         typed_req(ACT_NEXT, 8191, 8191, 127, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_NEXT, 5, 0, 1, 0, ST_BROKEN, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 1, 4096, 0, 4096, ST_OK, 0));
    directed_rows.insert(directed_rows.size(),
                         typed_req(ACT_LINK, 4096, 4096, 0, 4096, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_NEXT, 1, 0, 0));
    directed_rows.insert(directed_rows.size(),
                         typed_req(ACT_NEXT, 4096, 0, 0, 4096, ST_END, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 2, 4097, 0, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(),
                         typed_req(ACT_LINK, 2, 8191, 127, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 0, 3, 0, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_FREE, 8191, 0, 0, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_SCAN, 0, 0, 127));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 3, 7, 0, 7, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 7, 3, 0, 3, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_FREE, 3, 0, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_FREE, 1, 0, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_FREE, 10, 0, 0, 0, ST_BROKEN, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_FREE, 0, 0, 0, 0, ST_RANGE, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 5, 0, 0, 0, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_LINK, 9, 9, 0, 9, ST_OK, 0));
    directed_rows.insert(directed_rows.size(), typed_req(ACT_NEXT, 9, 0, 0, 9, ST_END, 0));
    directed_rows.insert(directed_rows.size(), make_req(ACT_SCAN, 0, 0, 64));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    in_tvalid <= 1'b0;

    foreach (phase_size[p]) begin
      write_blocks_in_use(BLK_W'(phase_size[p]));
      n = table_len();
      sent = 0;
      while (sent < phase_items[p]) begin
        if (n > 0 && $urandom_range(0, 3) != 0) begin
          send_chain_walk(n, got);
          sent += got;
        end else begin
          send_request(noise_item(n));
          sent++;
        end
      end
      in_tvalid <= 1'b0;
    end

    wait_idle();
    // Hold to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/bcte_pkg.sv
design/block_chain_table_engine.sv
sim/block_chain_table_engine_tb.sv
